/* hdl/oct_pkg.sv */
// Shared types and constants for the OOK remote code transmitter.
package oct_pkg;

	localparam int CODE_W = 24;
	localparam int LIMIT_W = 8;
	localparam int TICK_W = 8;
	localparam int FRAMES_W = 8;
	localparam int SHIFT_W = 5;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 1;

	localparam int CODE_BITS_DEF = 24;
	localparam int GAP_TICKS_DEF = 200;

	localparam logic [CFG_IDX_W-1:0] REG_CODE_WORD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_LIMIT = 1'b1;

	localparam logic [LIMIT_W-1:0] REPEAT_LIMIT_RST = 8'd49;
	localparam logic [FRAMES_W-1:0] FRAMES_MAX = 8'd255;

	localparam logic [TICK_W-1:0] SYNC_HIGH_AT = 8'd1;
	localparam logic [TICK_W-1:0] SYNC_LOW_AT = 8'd5;
	localparam logic [TICK_W-1:0] SYNC_END_AT = 8'd95;
	localparam logic [TICK_W-1:0] CELL_HIGH_AT = 8'd1;
	localparam logic [TICK_W-1:0] ONE_LOW_AT = 8'd8;
	localparam logic [TICK_W-1:0] ZERO_LOW_AT = 8'd4;
	localparam logic [TICK_W-1:0] CELL_END_AT = 8'd12;

	typedef enum logic [2:0] {
		PH_SYNC = 3'b001,
		PH_DATA = 3'b010,
		PH_GAP  = 3'b100
	} phase_t;

	typedef struct packed {
		logic line_level;
		logic frame_done;
		logic stop_request;
	} result_t;

endpackage

/* hdl/oct_if.sv */
// Stream interfaces for the input and result channels.
interface oct_in_if;
	logic valid;
	logic ready;
	logic timer_tick;
	logic send_enable;

	modport source (output valid, output timer_tick, output send_enable, input ready);
	modport sink (input valid, input timer_tick, input send_enable, output ready);
endinterface

interface oct_out_if;
	logic valid;
	logic ready;
	logic line_level;
	logic frame_done;
	logic stop_request;

	modport source (output valid, output line_level, output frame_done,
		output stop_request, input ready);
	modport sink (input valid, input line_level, input frame_done,
		input stop_request, output ready);
endinterface

/* hdl/oct_seq.sv */
// Frame sequencer: configuration registers, frame state and per-beat result.
module oct_seq
	import oct_pkg::*;
#(
	parameter int CODE_BITS = CODE_BITS_DEF,
	parameter int GAP_TICKS = GAP_TICKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 accept,
	input  logic                 timer_tick,
	input  logic                 send_enable,
	output result_t              result
);

	localparam int BPW = $clog2(CODE_BITS + 1);

	logic [CODE_W-1:0]   code_word_q;
	logic [LIMIT_W-1:0]  repeat_limit_q;
	logic [TICK_W-1:0]   tick_count_q, tick_count_n, tick_inc;
	phase_t              phase_q, phase_n;
	logic [BPW-1:0]      bit_pos_q, bit_pos_n, shift_full;
	logic [FRAMES_W-1:0] frames_q, frames_n;
	logic                line_q, line_n;
	logic                done, stop, active, cur_bit;
	logic [SHIFT_W-1:0]  shift;
	logic [31:0]         code_ext;
	logic [TICK_W-1:0]   low_at;

	assign active = accept && timer_tick && send_enable;
	assign tick_inc = tick_count_q + TICK_W'(1);
	assign shift_full = BPW'(CODE_BITS - 1) - bit_pos_q;
	assign shift = SHIFT_W'(shift_full);
	assign code_ext = 32'(code_word_q);
	assign cur_bit = code_ext[shift];
	assign low_at = cur_bit ? ONE_LOW_AT : ZERO_LOW_AT;

	always_comb begin
		tick_count_n = tick_count_q;
		phase_n = phase_q;
		bit_pos_n = bit_pos_q;
		frames_n = frames_q;
		line_n = line_q;
		done = 1'b0;
		stop = 1'b0;
		if (active) begin
			tick_count_n = tick_inc;
			case (phase_q)
				PH_SYNC: begin
					if (tick_inc == SYNC_HIGH_AT) begin
						line_n = 1'b1;
					end else if (tick_inc == SYNC_LOW_AT) begin
						line_n = 1'b0;
					end else if (tick_inc == SYNC_END_AT) begin
						line_n = 1'b1;
						tick_count_n = '0;
						phase_n = PH_DATA;
					end
				end
				PH_DATA: begin
					if (bit_pos_q < BPW'(CODE_BITS)) begin
						if (tick_inc == CELL_HIGH_AT) begin
							line_n = 1'b1;
						end else if (tick_inc == low_at) begin
							line_n = 1'b0;
						end else if (tick_inc == CELL_END_AT) begin
							line_n = 1'b1;
							bit_pos_n = bit_pos_q + BPW'(1);
							tick_count_n = '0;
						end
					end else begin
						phase_n = PH_GAP;
						tick_count_n = '0;
						bit_pos_n = '0;
						line_n = 1'b0;
					end
				end
				PH_GAP: begin
					if (tick_inc == TICK_W'(GAP_TICKS)) begin
						phase_n = PH_SYNC;
						tick_count_n = '0;
						if (frames_q != FRAMES_MAX) begin
							frames_n = frames_q + FRAMES_W'(1);
						end
						done = 1'b1;
						stop = (frames_n > repeat_limit_q);
					end
				end
				default: begin
					phase_n = PH_SYNC;
					tick_count_n = '0;
				end
			endcase
		end
	end

	assign result.line_level = line_n;
	assign result.frame_done = done;
	assign result.stop_request = stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_word_q <= '0;
			repeat_limit_q <= REPEAT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CODE_WORD: code_word_q <= cfg_data[CODE_W-1:0];
				REG_REPEAT_LIMIT: repeat_limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			phase_q <= PH_SYNC;
			bit_pos_q <= '0;
			frames_q <= '0;
			line_q <= 1'b0;
		end else begin
			tick_count_q <= tick_count_n;
			phase_q <= phase_n;
			bit_pos_q <= bit_pos_n;
			frames_q <= frames_n;
			line_q <= line_n;
		end
	end

endmodule

/* hdl/oct_out.sv */
// Result register: holds one beat and keeps the input open while it drains.
module oct_out
	import oct_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  result_t result,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t out_data,
	output logic    in_ready
);

	logic    valid_q;
	result_t data_q;

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= result;
		end
	end

endmodule

/* hdl/ook_remote_code_transmitter.sv */
// Top level of the OOK remote code transmitter.
//
// channel   dir  payload                                   accepted when
// in_ch     in   timer_tick, send_enable                   valid && ready
// out_ch    out  line_level, frame_done, stop_request      valid && ready
// cfg       in   cfg_index, cfg_data                       cfg_we
//
// One beat per cycle while the result register can drain; each input beat yields
// its result in the next cycle, from the frame-state update and the result register.
// Reset clears the frame state, the code word and sets the repeat limit to 49.
// A stalled result holds in the result register; input stays open while
// that register drains in the same cycle.
module ook_remote_code_transmitter
	import oct_pkg::*;
#(
	parameter int CODE_BITS = CODE_BITS_DEF,
	parameter int GAP_TICKS = GAP_TICKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	oct_in_if.sink               in_ch,
	oct_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic    accept, in_ready, out_valid;
	result_t result, out_data;

	assign accept = in_ch.valid && in_ready;
	assign in_ch.ready = in_ready;

	oct_seq #(
		.CODE_BITS (CODE_BITS),
		.GAP_TICKS (GAP_TICKS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.timer_tick  (in_ch.timer_tick),
		.send_enable (in_ch.send_enable),
		.result      (result)
	);

	oct_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.result    (result),
		.out_ready (out_ch.ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.in_ready  (in_ready)
	);

	assign out_ch.valid = out_valid;
	assign out_ch.line_level = out_data.line_level;
	assign out_ch.frame_done = out_data.frame_done;
	assign out_ch.stop_request = out_data.stop_request;

`ifndef SYNTHESIS
	a_stop_on_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.stop_request |-> out_ch.frame_done)
		else $error("stop_request without frame_done");

	a_gap_end_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.frame_done |-> !out_ch.line_level)
		else $error("line high at end of gap");

	a_idle_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_ch.timer_tick |=> out_ch.valid && !out_ch.frame_done)
		else $error("idle beat produced wrong result");
`endif

endmodule
